>>> rtl/msh_pkg.sv
// ----------------------------------------------------------------------------
// msh_pkg: shared types and constants for the string hash block
// MurmurHash2 mixing constants, the queue entry and the back end states.
// ----------------------------------------------------------------------------
package msh_pkg;

	localparam logic [31:0] MIX_MUL      = 32'h5bd1e995;
	localparam int          MIX_SHIFT    = 24;
	localparam int          AVAL_SHIFT_A = 13;
	localparam int          AVAL_SHIFT_B = 15;
	localparam logic [31:0] SEED_RESET   = 32'd32;

	// word of four bytes in byte count terms
	localparam logic [2:0]  FULL_COUNT   = 3'd4;

	// depth of the queue between front and back
	localparam int          QUEUE_DEPTH  = 2;

	// one classified request, handed from front to back
	typedef struct packed {
		logic [31:0] k;       // premixed word
		logic [23:0] tail;    // low three bytes for the tail step
		logic [2:0]  cnt;     // byte count, saturated to 0..4
		logic        start;   // begin a new hash from seed ^ len
		logic        last;    // finish and emit the hash
		logic [30:0] len;     // total length, used on start
	} msh_item_t;

	typedef enum logic [1:0] {
		ST_MIX,
		ST_AVAL,
		ST_FIN
	} msh_state_t;

endpackage

>>> rtl/murmur_string_hash.sv
// ----------------------------------------------------------------------------
// murmur_string_hash: 32-bit MurmurHash2 over a byte string
// Words arrive little-endian, one per request; the hash is returned once
// per string, after the last word and its tail bytes.
// ----------------------------------------------------------------------------
//   channel | signals                                              | dir
//   --------+------------------------------------------------------+-----
//   in      | in_valid, in_ready, data_word, byte_count, first,    | in
//           | last, total_length                                   |
//   out     | out_valid, out_ready, hash_value                     | out
//   cfg     | cfg_we, cfg_wdata (seed, reset value 32)             | in
//
// A full word that does not finish a string passes the back end without a hold; the front
// accepts one request per cycle while the queue has room.
// A finishing request holds the back end through its mix, avalanche and final states, set by
// the one shared multiplier that does the mix, the tail and the avalanche.
// A result passes the two front stages, the queue and those back end states before it appears.
// Reset is asynchronous and needs no clearing pass; either side may stall.
// ----------------------------------------------------------------------------
module murmur_string_hash import msh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        first,
	input  logic        last,
	input  logic [30:0] total_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] hash_value
);

	logic      push_valid, push_ready, pop_valid, pop_ready;
	msh_item_t push_item, pop_item;

	msh_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_word   (data_word),
		.byte_count  (byte_count),
		.first       (first),
		.last        (last),
		.total_length(total_length),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_item   (push_item)
	);

	msh_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item)
	);

	msh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hash_value(hash_value)
	);

endmodule

>>> rtl/msh_front.sv
// ----------------------------------------------------------------------------
// msh_front: request intake and word premix
// Classifies each request and runs the input-only part of the word mix in
// two registered multiply stages before handing it to the queue.
// ----------------------------------------------------------------------------
module msh_front import msh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        first,
	input  logic        last,
	input  logic [30:0] total_length,
	output logic        push_valid,
	input  logic        push_ready,
	output msh_item_t   push_item
);

	logic        v_s1, v_s2;
	logic        open_q;
	logic        adv_s1, adv_s2, take;
	logic [2:0]  cnt_sat;
	logic        last_eff;
	logic [31:0] prod_s1;
	logic [31:0] kmix;
	msh_item_t   item_s1, item_s2;
	msh_item_t   item_nx;

	// clamp count and force a short word to finish the string
	always_comb begin
		cnt_sat  = (byte_count inside {3'd5, 3'd6, 3'd7}) ? FULL_COUNT : byte_count;
		last_eff = last || (cnt_sat != FULL_COUNT);
		kmix     = prod_s1 ^ (prod_s1 >> MIX_SHIFT);
	end

	// merge the premixed word into the stage 1 request
	always_comb begin
		item_nx   = item_s1;
		item_nx.k = kmix * MIX_MUL;
	end

	// advance when the next stage frees up
	assign adv_s2   = !v_s2 || push_ready;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			open_q <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (take)   open_q <= !last_eff;
		end
	end

	// stage 1: capture request, first multiply
	always_ff @(posedge clk) begin
		if (take) begin
			prod_s1       <= data_word * MIX_MUL;
			item_s1.k     <= '0;
			item_s1.tail  <= data_word[23:0];
			item_s1.cnt   <= cnt_sat;
			item_s1.start <= first || !open_q;
			item_s1.last  <= last_eff;
			item_s1.len   <= total_length;
		end
	end

	// stage 2: xor-shift and second multiply
	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			item_s2 <= item_nx;
		end
	end

	assign push_valid = v_s2;
	assign push_item  = item_s2;

endmodule

>>> rtl/msh_queue.sv
// ----------------------------------------------------------------------------
// msh_queue: small request queue
// Register FIFO that decouples the front stages from the back end.
// ----------------------------------------------------------------------------
module msh_queue import msh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  msh_item_t push_item,
	output logic      pop_valid,
	input  logic      pop_ready,
	output msh_item_t pop_item
);

	localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	msh_item_t      mem_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0] count_q;
	logic           push, pop;

	assign push_ready = (count_q != QCW'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	// store entry
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> rtl/msh_back.sv
// ----------------------------------------------------------------------------
// msh_back: hash recurrence, tail step and avalanche
// One shared multiplier serves the word mix, the tail and the avalanche;
// the finished hash waits in an output register.
// ----------------------------------------------------------------------------
module msh_back import msh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        pop_valid,
	output logic        pop_ready,
	input  msh_item_t   pop_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] hash_value
);

	msh_state_t  state_q, state_d;
	logic [31:0] seed_q;
	logic [31:0] hash_q;
	logic [31:0] out_q;
	logic        out_valid_q;
	logic        load_hash, sel_aval, load_out;
	logic [31:0] base, tail_bits, operand, mul_a, prod, mixed;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_MIX:  if (pop_valid && pop_item.last) state_d = ST_AVAL;
			ST_AVAL: state_d = ST_FIN;
			ST_FIN:  if (!out_valid_q || out_ready) state_d = ST_MIX;
			default: state_d = ST_MIX;
		endcase
	end

	// state outputs
	always_comb begin
		pop_ready = 1'b0;
		load_hash = 1'b0;
		sel_aval  = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_MIX: begin
				pop_ready = 1'b1;
				load_hash = pop_valid;
			end
			ST_AVAL: begin
				load_hash = 1'b1;
				sel_aval  = 1'b1;
			end
			ST_FIN: load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// word or tail step, avalanche multiply shares the unit
	always_comb begin
		base      = pop_item.start ? (seed_q ^ {1'b0, pop_item.len}) : hash_q;
		tail_bits = '0;
		if (pop_item.cnt >= 3'd3) tail_bits[23:16] = pop_item.tail[23:16];
		if (pop_item.cnt >= 3'd2) tail_bits[15:8]  = pop_item.tail[15:8];
		if (pop_item.cnt >= 3'd1) tail_bits[7:0]   = pop_item.tail[7:0];
		operand = (pop_item.cnt == FULL_COUNT) ? base : (base ^ tail_bits);
		mul_a   = sel_aval ? (hash_q ^ (hash_q >> AVAL_SHIFT_A)) : operand;
		prod    = mul_a * MIX_MUL;
		if (pop_item.cnt == FULL_COUNT)
			mixed = prod ^ pop_item.k;
		else if (pop_item.cnt == 3'd0)
			mixed = operand;
		else
			mixed = prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_MIX;
			seed_q      <= SEED_RESET;
			hash_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) seed_q <= cfg_wdata;
			if (load_hash) hash_q <= sel_aval ? prod : mixed;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// final xor-shift into the output register
	always_ff @(posedge clk) begin
		if (load_out) out_q <= hash_q ^ (hash_q >> AVAL_SHIFT_B);
	end

	assign out_valid  = out_valid_q;
	assign hash_value = out_q;

endmodule

>>> rtl/msh_checker.sv
// ----------------------------------------------------------------------------
// msh_checker: port-level checks for the string hash block
// Tracks strings that are finished at the input but not yet returned.
// ----------------------------------------------------------------------------
module msh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [2:0]  byte_count,
	input logic        last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] hash_value
);

	logic [3:0] pending_q;
	logic       fin_in, fin_out;

	// a request finishes a string when marked last or short
	assign fin_in  = in_valid && in_ready && (last || byte_count < 3'd4);
	assign fin_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pending_q <= '0;
		else if (fin_in && !fin_out)
			pending_q <= pending_q + 1'b1;
		else if (fin_out && !fin_in)
			pending_q <= pending_q - 1'b1;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before it was taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(hash_value))
		else $error("result changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 4'd0)
		else $error("result without a finished string");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 4'd6)
		else $error("more strings in flight than the block can hold");

endmodule

bind murmur_string_hash msh_checker u_msh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.byte_count(byte_count),
	.last      (last),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.hash_value(hash_value)
);

>>> test/tb_murmur_string_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_murmur_string_hash: self-checking bench for the string hash block
// Drives strings word by word, some ragged, through the request channel.
// A scoreboard predicts each finished hash and compares it with the returned
// result. Both channels idle at random. The seed register is reprogrammed
// between phases while the block is quiet.
// ----------------------------------------------------------------------------
module tb_murmur_string_hash;

	localparam bit [31:0]   MURMUR_M      = 32'h5bd1e995;
	localparam int          MURMUR_R      = 24;
	localparam int          FINAL_SHIFT_A = 13;
	localparam int          FINAL_SHIFT_B = 15;
	localparam bit [31:0]   SEED_AT_RESET = 32'd32;
	localparam bit [2:0]    WORD_BYTES    = 3'd4;
	localparam int          SETTLE_CYCLES = 12;
	localparam int          SHOWN_ERRORS  = 10;

	// predict finished hashes and hold them until the block returns them
	class hash_scoreboard;
		bit [31:0] seed;
		bit [31:0] running;
		bit        open;
		bit [31:0] expected_hashes[$];
		int        failures;

		function new();
			seed = SEED_AT_RESET;
			running = '0;
			open = 1'b0;
			failures = 0;
		endfunction

		function int unsigned pending();
			return expected_hashes.size();
		endfunction

		// advance the hash by one accepted request
		function void note_request(bit [31:0] word, bit [2:0] count, bit first_w, bit last_w,
			bit [30:0] length);
			bit [31:0] h;
			bit [31:0] k;
			bit [2:0]  n;
			bit        ends;
			n = (count > WORD_BYTES) ? WORD_BYTES : count;
			ends = last_w || (n < WORD_BYTES);
			// start from the seed on a first word or when no string is open
			if (first_w || !open) begin
				h = seed ^ {1'b0, length};
			end else begin
				h = running;
			end
			if (n == WORD_BYTES) begin
				k = word * MURMUR_M;
				k ^= k >> MURMUR_R;
				k = k * MURMUR_M;
				h = (h * MURMUR_M) ^ k;
			end else begin
				// fold the tail bytes, highest first
				if (n >= 3) h ^= {8'h00, word[23:16], 16'h0000};
				if (n >= 2) h ^= {16'h0000, word[15:8], 8'h00};
				if (n >= 1) begin
					h ^= {24'h000000, word[7:0]};
					h = h * MURMUR_M;
				end
			end
			if (ends) begin
				h ^= h >> FINAL_SHIFT_A;
				h = h * MURMUR_M;
				h ^= h >> FINAL_SHIFT_B;
				expected_hashes.push_back(h);
			end
			running = h;
			open = !ends;
		endfunction

		// compare a returned hash with the oldest prediction
		function void check_hash(bit [31:0] actual);
			bit [31:0] wanted;
			if (expected_hashes.size() == 0) begin
				failures++;
				if (failures <= SHOWN_ERRORS)
					$display("%0t: unexpected hash %08h", $realtime, actual);
			end else begin
				wanted = expected_hashes.pop_front();
				if (wanted != actual) begin
					failures++;
					if (failures <= SHOWN_ERRORS)
						$display("%0t: hash_value expected %08h got %08h", $realtime,
							wanted, actual);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        first;
	logic        last;
	logic [30:0] total_length;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] hash_value;

	hash_scoreboard hashes;
	bit             quiet;
	int unsigned    requests_sent;

	murmur_string_hash i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_word    (data_word),
		.byte_count   (byte_count),
		.first        (first),
		.last         (last),
		.total_length (total_length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hash_value   (hash_value)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// drop the run if it hangs
	initial begin
		#5_000_000;
		$display("tb_murmur_string_hash: errors");
		$finish;
	end

	// accept results with random stalls and check each one
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				hashes.check_hash(hash_value);
			out_ready <= quiet || ($urandom_range(99) >= 18);
		end
	end

	// present one request, after a random idle gap, and hold it until taken
	task automatic send_request(input bit [31:0] word, input bit [2:0] count, input bit first_w,
		input bit last_w, input bit [30:0] length);
		int unsigned gap;
		gap = 0;
		if (!quiet)
			while ($urandom_range(99) < 18) gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_word <= word;
		byte_count <= count;
		first <= first_w;
		last <= last_w;
		total_length <= length;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		hashes.note_request(word, count, first_w, last_w, length);
		requests_sent++;
	endtask

	// send a well-formed string; stop early after stop_after words if nonzero
	task automatic send_string(input int unsigned length, input int unsigned stop_after);
		bit [30:0]   declared;
		bit [2:0]    count;
		bit          is_first;
		int unsigned left;
		int unsigned words;
		declared = ($urandom_range(9) == 0) ? 31'($urandom) : 31'(length);
		left = length;
		is_first = 1'b1;
		words = 0;
		do begin
			count = (left >= 4) ? WORD_BYTES : 3'(left);
			send_request($urandom, count, is_first, left <= 4, declared);
			is_first = 1'b0;
			left -= count;
			words++;
		end while (left != 0 && words != stop_after);
	endtask

	// mix of clean strings, loose requests and cut-off strings
	task automatic run_phase(input int unsigned budget);
		int unsigned target;
		int unsigned pick;
		int unsigned length;
		target = requests_sent + budget;
		while (requests_sent < target) begin
			pick = $urandom_range(99);
			length = ($urandom_range(9) == 0) ? $urandom_range(160, 25) : $urandom_range(24, 0);
			if (pick < 78)
				send_string(length, 0);
			else if (pick < 90)
				send_request($urandom, 3'($urandom_range(7)), 1'($urandom_range(1)),
					1'($urandom_range(1)), 31'($urandom));
			else
				send_string(length | 8, $urandom_range(2, 1));
		end
	endtask

	// close any open string, then wait for the block to go quiet
	task automatic drain();
		if (hashes.open)
			send_request($urandom, 3'd0, 1'b1, 1'b1, 31'($urandom));
		in_valid <= 1'b0;
		while (hashes.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(input bit [31:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		hashes.seed = value;
		cfg_we <= 1'b0;
	endtask

	initial begin
		hashes = new();
		quiet = 1'b0;
		requests_sent = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		data_word <= '0;
		byte_count <= '0;
		first <= 1'b0;
		last <= 1'b0;
		total_length <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty strings, shortest and longest declared length
		send_request(32'h00000000, 3'd0, 1'b1, 1'b1, 31'd0);
		send_request(32'hffffffff, 3'd0, 1'b1, 1'b1, 31'h7fffffff);
		// one to three tail bytes with unused bytes set
		send_request(32'hffffffff, 3'd1, 1'b1, 1'b1, 31'd1);
		send_request(32'hffffffff, 3'd2, 1'b1, 1'b1, 31'd2);
		send_request(32'hffffffff, 3'd3, 1'b1, 1'b1, 31'd3);
		// last word full, no tail step
		send_request(32'h00000000, 3'd4, 1'b1, 1'b1, 31'd4);
		send_request(32'hffffffff, 3'd4, 1'b1, 1'b1, 31'd4);
		// byte counts above four saturate
		send_request(32'h89abcdef, 3'd5, 1'b1, 1'b1, 31'd4);
		send_request(32'h89abcdef, 3'd6, 1'b1, 1'b1, 31'd4);
		send_request(32'h89abcdef, 3'd7, 1'b1, 1'b1, 31'd4);
		// short word without last still finishes
		send_request(32'h00636261, 3'd2, 1'b1, 1'b0, 31'd2);
		// no first while idle starts a string anyway
		send_request(32'h12345678, 3'd4, 1'b0, 1'b1, 31'd4);
		// first while open drops the open string
		send_request(32'h01020304, 3'd4, 1'b1, 1'b0, 31'd12);
		send_request(32'h05060708, 3'd4, 1'b1, 1'b0, 31'd8);
		send_request(32'h090a0b0c, 3'd4, 1'b0, 1'b1, 31'd8);
		// full word then three tail bytes
		send_request(32'h64636261, 3'd4, 1'b1, 1'b0, 31'd7);
		send_request(32'hff676665, 3'd3, 1'b0, 1'b1, 31'd7);
		// declared length that does not match, length ignored after first
		send_request(32'hdeadbeef, 3'd4, 1'b1, 1'b0, 31'd0);
		send_request(32'hcafef00d, 3'd4, 1'b0, 1'b1, 31'h55555555);
		// saturated count mid-string, then an empty short word ends it
		send_request(32'h0badf00d, 3'd4, 1'b1, 1'b0, 31'h2aaaaaaa);
		send_request(32'h76543210, 3'd7, 1'b0, 1'b0, 31'd0);
		send_request(32'hffffffff, 3'd0, 1'b0, 1'b0, 31'd0);

		run_phase(190);
		for (int p = 1; p <= 5; p++) begin
			drain();
			case (p)
				1: write_seed(32'h00000000);
				2: write_seed(32'hffffffff);
				4: write_seed(32'h80000000);
				default: write_seed($urandom);
			endcase
			// run one phase with no idling on either side
			quiet = (p == 2);
			run_phase(210);
			quiet = 1'b0;
		end
		drain();

		if (hashes.failures == 0) begin
			$display("tb_murmur_string_hash: clean");
		end else begin
			$display("tb_murmur_string_hash: errors");
		end
		$finish;
	end

endmodule
